/* src/crc16fr_pkg.sv */
`timescale 1ns / 1ps
// Package for the CRC16 frame receiver: frame phase codes, result kinds
// and the byte-wise CCITT CRC update. No dependencies.
package crc16fr_pkg;

  // Frame phase, one code per byte position class
  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_COMMAND  = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CRC_HIGH = 3'd4,
    PH_CRC_LOW  = 3'd5
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  localparam logic [7:0] START_RESET = 8'h2A;
  localparam logic [2:0] REG_START_VALUE = 3'd0;

  // Byte-wise CCITT CRC16 update (poly 0x1021, not reflected)
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = {crc[7:0], crc[15:8]} ^ {8'h00, b};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

endpackage

/* src/crc16_frame_receiver_top.sv */
`timescale 1ns / 1ps
// Top level of the CRC16 frame receiver: frame tracking, CRC check and
// result register. Depends on crc16fr_pkg.

// Byte-serial deframer for frames of start, length, command, payload and a
// big-endian CRC16 (CCITT, seeded with the start value, covering length,
// command and payload). Each payload byte yields a result carrying the frame
// command and its index; the low CRC byte yields an end-of-frame result with
// crc_good; a non-start byte while hunting yields a framing-error result.
// Header and high CRC bytes yield nothing. The frame state and the CRC update
// settle in one pass from the input port to the result register, so a beat is
// taken in every cycle while the result register is empty or being drained.
// The start value is written at byte
// address 0 of the APB port and takes effect at the next hunt.
module crc16_frame_receiver_top
  import crc16fr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_cmd_byte,
  output logic [7:0]  out_payload_index,
  output logic        out_crc_good,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  start_value_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  command_hold_r, command_hold_nxt;
  logic [7:0]  payload_count_r, payload_count_nxt;
  logic [15:0] crc_accum_r, crc_accum_nxt;
  logic [7:0]  crc_high_hold_r, crc_high_hold_nxt;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  payload_byte_r, cmd_byte_r, payload_index_r;
  logic        crc_good_r, last_r;

  logic        emit;
  logic [1:0]  kind_nxt;
  logic [7:0]  payload_byte_nxt, cmd_byte_nxt, payload_index_nxt;
  logic        crc_good_nxt, last_nxt;
  logic        in_beat;
  logic [15:0] crc_upd;
  logic [7:0]  count_inc;

  // Config port: always ready, single register at index 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_START_VALUE[0]) ? {24'h0, start_value_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_value_r <= START_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_START_VALUE[0]) begin
      start_value_r <= pwdata[7:0];
    end
  end

  // Take a beat whenever the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_beat  = in_valid && in_ready;
  assign crc_upd   = crc_step(crc_accum_r, in_rx_byte);
  assign count_inc = payload_count_r + 8'd1;

  // Frame tracking and result formation
  always_comb begin
    phase_nxt         = phase_r;
    frame_length_nxt  = frame_length_r;
    command_hold_nxt  = command_hold_r;
    payload_count_nxt = payload_count_r;
    crc_accum_nxt     = crc_accum_r;
    crc_high_hold_nxt = crc_high_hold_r;
    emit              = 1'b0;
    kind_nxt          = KIND_ERROR;
    payload_byte_nxt  = 8'h00;
    cmd_byte_nxt      = 8'h00;
    payload_index_nxt = 8'h00;
    crc_good_nxt      = 1'b0;
    last_nxt          = 1'b0;
    unique case (phase_r)
      PH_LENGTH: begin
        frame_length_nxt = in_rx_byte;
        crc_accum_nxt    = crc_upd;
        phase_nxt        = PH_COMMAND;
      end
      PH_COMMAND: begin
        command_hold_nxt  = in_rx_byte;
        crc_accum_nxt     = crc_upd;
        payload_count_nxt = 8'h00;
        phase_nxt         = (frame_length_r == 8'h00) ? PH_CRC_HIGH : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_accum_nxt     = crc_upd;
        emit              = 1'b1;
        kind_nxt          = KIND_PAYLOAD;
        payload_byte_nxt  = in_rx_byte;
        cmd_byte_nxt      = command_hold_r;
        payload_index_nxt = payload_count_r;
        payload_count_nxt = count_inc;
        if (count_inc == frame_length_r) begin
          phase_nxt = PH_CRC_HIGH;
        end
      end
      PH_CRC_HIGH: begin
        crc_high_hold_nxt = in_rx_byte;
        phase_nxt         = PH_CRC_LOW;
      end
      PH_CRC_LOW: begin
        emit              = 1'b1;
        kind_nxt          = KIND_END;
        cmd_byte_nxt      = command_hold_r;
        crc_good_nxt      = ({crc_high_hold_r, in_rx_byte} == crc_accum_r);
        last_nxt          = 1'b1;
        phase_nxt         = PH_HUNT;
      end
      default: begin
        // hunt: open a frame on the start byte, flag anything else
        if (in_rx_byte == start_value_r) begin
          crc_accum_nxt     = {8'h00, start_value_r};
          payload_count_nxt = 8'h00;
          phase_nxt         = PH_LENGTH;
        end else begin
          phase_nxt = PH_HUNT;
          emit      = 1'b1;
          kind_nxt  = KIND_ERROR;
        end
      end
    endcase
  end

  // Frame state registers advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HUNT;
      frame_length_r  <= 8'h00;
      command_hold_r  <= 8'h00;
      payload_count_r <= 8'h00;
      crc_accum_r     <= {8'h00, START_RESET};
      crc_high_hold_r <= 8'h00;
    end else if (in_beat) begin
      phase_r         <= phase_nxt;
      frame_length_r  <= frame_length_nxt;
      command_hold_r  <= command_hold_nxt;
      payload_count_r <= payload_count_nxt;
      crc_accum_r     <= crc_accum_nxt;
      crc_high_hold_r <= crc_high_hold_nxt;
    end
  end

  // Result register: load on a beat that emits, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && emit) begin
      kind_r          <= kind_nxt;
      payload_byte_r  <= payload_byte_nxt;
      cmd_byte_r      <= cmd_byte_nxt;
      payload_index_r <= payload_index_nxt;
      crc_good_r      <= crc_good_nxt;
      last_r          <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_payload_byte  = payload_byte_r;
  assign out_cmd_byte      = cmd_byte_r;
  assign out_payload_index = payload_index_r;
  assign out_crc_good      = crc_good_r;
  assign out_last          = last_r;

endmodule

/* sim/tb_crc16_frame_receiver_top.sv */
`timescale 1ns / 1ps
// Testbench for crc16_frame_receiver_top: drives framed byte streams with random
// handshake gaps and checks every result against a built-in deframer predictor.
// Depends on crc16fr_pkg and the receiver RTL.
module tb_crc16_frame_receiver_top
  import crc16fr_pkg::*;
();

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int HOLD_AFTER  = 300;
  localparam int PRINT_CAP   = 100;

  typedef struct {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] command;
    logic [7:0] index;
    logic       crc_good;
    logic       last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_cmd_byte;
  logic [7:0]  out_payload_index;
  logic        out_crc_good;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = REG_START_VALUE;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and scoreboard storage
  logic [7:0]    link_bytes[$];
  logic [7:0]    frame_buf[$];
  frame_result_t deframed_results[$];
  int            bytes_queued = 0;
  int            bytes_taken = 0;
  int            mismatches = 0;
  logic          calm = 1'b0;

  // Predictor state
  phase_t      rx_phase = PH_HUNT;
  logic [7:0]  rx_start = START_RESET;
  logic [7:0]  rx_len = 8'h00;
  logic [7:0]  rx_cmd = 8'h00;
  logic [7:0]  rx_count = 8'h00;
  logic [15:0] rx_crc = {8'h00, START_RESET};
  logic [7:0]  rx_crc_hi = 8'h00;

  // Handshake pacing
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int quiet = 0;

  crc16_frame_receiver_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_payload_byte(out_payload_byte), .out_cmd_byte(out_cmd_byte),
    .out_payload_index(out_payload_index), .out_crc_good(out_crc_good),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Bit-serial CCITT CRC, MSB first, poly 0x1021
  function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic frame_result_t result_of(input kind_t k, input logic [7:0] pb,
                                              input logic [7:0] cmd, input logic [7:0] idx,
                                              input logic good, input logic fin);
    frame_result_t r;
    r.kind = k;
    r.payload_byte = pb;
    r.command = cmd;
    r.index = idx;
    r.crc_good = good;
    r.last = fin;
    return r;
  endfunction

  // Advance the deframer by one accepted byte and queue any result it yields
  task automatic predict_byte(input logic [7:0] b);
    case (rx_phase)
      PH_LENGTH: begin
        rx_len = b;
        rx_crc = ccitt_next(rx_crc, b);
        rx_phase = PH_COMMAND;
      end
      PH_COMMAND: begin
        rx_cmd = b;
        rx_crc = ccitt_next(rx_crc, b);
        rx_count = 8'h00;
        rx_phase = (rx_len == 8'h00) ? PH_CRC_HIGH : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        rx_crc = ccitt_next(rx_crc, b);
        deframed_results.push_back(result_of(KIND_PAYLOAD, b, rx_cmd, rx_count, 1'b0, 1'b0));
        rx_count = rx_count + 8'd1;
        if (rx_count == rx_len) rx_phase = PH_CRC_HIGH;
      end
      PH_CRC_HIGH: begin
        rx_crc_hi = b;
        rx_phase = PH_CRC_LOW;
      end
      PH_CRC_LOW: begin
        deframed_results.push_back(result_of(KIND_END, 8'h00, rx_cmd, 8'h00,
                                             {rx_crc_hi, b} == rx_crc, 1'b1));
        rx_phase = PH_HUNT;
      end
      default: begin
        if (b == rx_start) begin
          rx_crc = {8'h00, rx_start};
          rx_count = 8'h00;
          rx_phase = PH_LENGTH;
        end else begin
          rx_phase = PH_HUNT;
          deframed_results.push_back(result_of(KIND_ERROR, 8'h00, 8'h00, 8'h00,
                                               1'b0, 1'b0));
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("mismatch @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic push_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Build a whole frame in frame_buf; fill < 0 gives random payload bytes
  task automatic build_frame(input logic [7:0] sof, input int len, input logic [7:0] cmd,
                             input int fill, input bit spoil);
    logic [15:0] crc;
    logic [7:0]  b;
    frame_buf.delete();
    crc = {8'h00, sof};
    frame_buf.push_back(sof);
    frame_buf.push_back(len[7:0]);
    crc = ccitt_next(crc, len[7:0]);
    frame_buf.push_back(cmd);
    crc = ccitt_next(crc, cmd);
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : fill[7:0];
      frame_buf.push_back(b);
      crc = ccitt_next(crc, b);
    end
    if (spoil) crc = crc ^ (16'h1 << $urandom_range(0, 15));
    frame_buf.push_back(crc[15:8]);
    frame_buf.push_back(crc[7:0]);
  endtask

  task automatic push_slice(input int from, input int upto);
    for (int i = from; i < upto; i++) push_byte(frame_buf[i]);
  endtask

  task automatic queue_frame(input int len, input logic [7:0] cmd, input int fill,
                             input bit spoil);
    build_frame(rx_start, len, cmd, fill, spoil);
    push_slice(0, frame_buf.size());
  endtask

  // Mostly well-formed frames with random content, some noise and cut-off frames
  task automatic random_traffic(input int count);
    int goal;
    int pick;
    goal = bytes_queued + count;
    while (bytes_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        queue_frame($urandom_range(0, 12), 8'($urandom), -1, $urandom_range(0, 4) == 0);
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end else begin
        build_frame(rx_start, $urandom_range(0, 8), 8'($urandom), -1, 1'b0);
        push_slice(0, $urandom_range(1, frame_buf.size() - 1));
      end
    end
  endtask

  // Wait until every byte is taken and every result is in, then let the pipe settle
  task automatic drain;
    while (link_bytes.size() != 0 || in_valid || deframed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Write the start value, then read it back
  task automatic write_start_value(input logic [7:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_START_VALUE;
    pwdata <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rx_start = v;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("start_value readback", int'(prdata[7:0]), int'(v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sender: hold each beat until taken, feed the predictor on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_byte(in_rx_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (link_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= link_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (deframed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", out_kind));
      end else begin
        want = deframed_results.pop_front();
        check_field("kind", int'(out_kind), int'(want.kind));
        check_field("payload_byte", int'(out_payload_byte), int'(want.payload_byte));
        check_field("cmd_byte", int'(out_cmd_byte), int'(want.command));
        check_field("payload_index", int'(out_payload_index), int'(want.index));
        check_field("crc_good", int'(out_crc_good), int'(want.crc_good));
        check_field("last", int'(out_last), int'(want.last));
      end
    end
  end

  // Watchdog on cycles with no traffic on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty payload, extreme bytes, bad CRC, framing errors
    queue_frame(0, 8'h00, -1, 1'b0);
    queue_frame(1, 8'hFF, 255, 1'b0);
    queue_frame(2, 8'h5A, 0, 1'b1);
    push_byte(8'h00);
    push_byte(8'hFF);
    drain();

    // Start byte of zero, one full-length payload
    write_start_value(8'h00);
    queue_frame(1, 8'h81, int'(START_RESET), 1'b0);
    queue_frame(255, 8'h7E, -1, 1'b0);
    random_traffic(250);
    drain();

    // Change the start value in the middle of a frame
    build_frame(rx_start, 3, 8'hC3, -1, 1'b0);
    push_slice(0, 4);
    drain();
    write_start_value(8'hFF);
    push_slice(4, frame_buf.size());
    random_traffic(250);
    drain();

    write_start_value(8'($urandom));
    random_traffic(250);
    drain();

    // Last stretch at full rate on both sides
    write_start_value(START_RESET);
    calm <= 1'b1;
    random_traffic(250);
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
